/* rtl/assert_macros.svh */
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define TFN_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define TFN_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/tfn_pkg.sv */
`timescale 1ns / 1ps
package tfn_pkg;

    localparam int COORD_FRAC_BITS = 14;
    localparam int COORD_W   = 16;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int CROSS_W   = PROD_W + 1;
    localparam int NORM_TOP  = 29;
    localparam int R_W       = NORM_TOP + 1;
    localparam int SUM_W     = 2 * R_W + 2;
    localparam int ROOT_W    = SUM_W / 2;
    localparam int BIT_W     = SUM_W + 1;
    localparam int DIV_W     = R_W + COORD_FRAC_BITS + 1;
    localparam int POS_W     = $clog2(CROSS_W);
    localparam int CNT_W     = $clog2(DIV_W + 1);

    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] az;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by_coord;
        logic signed [COORD_W-1:0] bz;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
    } tri_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] vertex_x;
        logic signed [COORD_W-1:0] vertex_y;
        logic signed [COORD_W-1:0] vertex_z;
        logic signed [COORD_W-1:0] normal_x;
        logic signed [COORD_W-1:0] normal_y;
        logic signed [COORD_W-1:0] normal_z;
        logic                      degenerate;
        logic                      last_vertex;
    } result_t;

    typedef struct packed {
        tri_t verts;
        logic flat;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_push_t;

    typedef struct packed {
        logic     full;
        logic     empty;
        q_entry_t head;
    } q_stat_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CROSS,
        BK_MAG,
        BK_MAX,
        BK_SHIFT,
        BK_SQUARE,
        BK_ROOT,
        BK_DIV
    } back_state_t;

    function automatic logic [POS_W-1:0] msb_index(input logic [CROSS_W-1:0] m);
        logic [POS_W-1:0] p;
        p = '0;
        for (int i = 0; i < CROSS_W; i++) begin
            if (m[i])
            begin
                p = POS_W'(i);
            end
        end
        return p;
    endfunction

endpackage

/* rtl/tfn_front.sv */
`timescale 1ns / 1ps
module tfn_front import tfn_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  tri_t    triangle,
    input  logic    cfg_we,
    input  logic    cfg_wdata,
    input  q_stat_t q_stat,
    output logic    busy,
    output q_push_t push
);

    logic flat_shading_reg;
    logic flat_shading_next;

    always_comb
    begin
        flat_shading_next = cfg_we ? cfg_wdata : flat_shading_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flat_shading_reg <= 1'b1;
        end
        else
        begin
            flat_shading_reg <= flat_shading_next;
        end
    end

    // tag each triangle with the shading mode in force when it is taken
    always_comb
    begin
        busy             = q_stat.full;
        push.valid       = start && !q_stat.full;
        push.entry.verts = triangle;
        push.entry.flat  = flat_shading_reg;
    end

endmodule

/* rtl/tfn_queue.sv */
`timescale 1ns / 1ps
module tfn_queue import tfn_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  q_push_t push,
    input  logic    pop,
    output q_stat_t q_stat
);

    q_entry_t   slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    always_comb
    begin
        do_push     = push.valid && (count_reg != 2'd2);
        do_pop      = pop && (count_reg != 2'd0);
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
        q_stat.full  = (count_reg == 2'd2);
        q_stat.empty = (count_reg == 2'd0);
        q_stat.head  = slot_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push.entry;
        end
    end

endmodule

/* rtl/tfn_back.sv */
`timescale 1ns / 1ps
module tfn_back import tfn_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  q_stat_t q_stat,
    output logic    pop,
    output result_t result,
    output logic    result_strobe
);

    back_state_t              state_reg, state_next;
    logic                     emit_reg, emit_next;
    q_entry_t                 entry_reg, entry_next;
    logic [1:0]               k_reg, k_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic signed [CROSS_W-1:0] n_reg [3];
    logic signed [CROSS_W-1:0] n_next [3];
    logic [CROSS_W-1:0]       r_reg [3];
    logic [CROSS_W-1:0]       r_next [3];
    logic [POS_W-1:0]         p_reg, p_next;
    logic [SUM_W-1:0]         sum_reg, sum_next;
    logic [BIT_W-1:0]         res_reg, res_next;
    logic [BIT_W-1:0]         bit_reg, bit_next;
    logic [DIV_W-1:0]         dvd_reg, dvd_next;
    logic [ROOT_W:0]          rem_reg, rem_next;
    logic signed [COORD_W-1:0] nrm_reg [3];
    logic signed [COORD_W-1:0] nrm_next [3];
    logic                     degen_reg, degen_next;
    result_t                  result_reg, result_next;
    logic                     strobe_reg, strobe_next;

    logic signed [DIFF_W-1:0] d1 [3];
    logic signed [DIFF_W-1:0] d2 [3];
    logic signed [DIFF_W-1:0] ma, mb, mc, md;
    logic signed [PROD_W-1:0] prod_a, prod_b;
    logic [CROSS_W-1:0]       m_max;
    logic [2*R_W-1:0]         sq;
    logic [BIT_W-1:0]         trial;
    logic [ROOT_W-1:0]        len;
    logic [ROOT_W:0]          rem_sh;
    logic                     ge;
    logic [DIV_W-1:0]         q;
    logic                     load_next;

    // component differences of the triangle edges
    always_comb
    begin
        d1[0] = {entry_reg.verts.ax[COORD_W-1], entry_reg.verts.ax}
              - {entry_reg.verts.bx[COORD_W-1], entry_reg.verts.bx};
        d1[1] = {entry_reg.verts.ay[COORD_W-1], entry_reg.verts.ay}
              - {entry_reg.verts.by_coord[COORD_W-1], entry_reg.verts.by_coord};
        d1[2] = {entry_reg.verts.az[COORD_W-1], entry_reg.verts.az}
              - {entry_reg.verts.bz[COORD_W-1], entry_reg.verts.bz};
        d2[0] = {entry_reg.verts.bx[COORD_W-1], entry_reg.verts.bx}
              - {entry_reg.verts.cx[COORD_W-1], entry_reg.verts.cx};
        d2[1] = {entry_reg.verts.by_coord[COORD_W-1], entry_reg.verts.by_coord}
              - {entry_reg.verts.cy[COORD_W-1], entry_reg.verts.cy};
        d2[2] = {entry_reg.verts.bz[COORD_W-1], entry_reg.verts.bz}
              - {entry_reg.verts.cz[COORD_W-1], entry_reg.verts.cz};
    end

    // one cross component per cycle
    always_comb
    begin
        case (k_reg)
            2'd0:
            begin
                ma = d1[1]; mb = d2[2]; mc = d1[2]; md = d2[1];
            end
            2'd1:
            begin
                ma = d1[2]; mb = d2[0]; mc = d1[0]; md = d2[2];
            end
            default:
            begin
                ma = d1[0]; mb = d2[1]; mc = d1[1]; md = d2[0];
            end
        endcase
        prod_a = ma * mb;
        prod_b = mc * md;
    end

    always_comb
    begin
        m_max = r_reg[0];
        if (r_reg[1] > m_max)
        begin
            m_max = r_reg[1];
        end
        if (r_reg[2] > m_max)
        begin
            m_max = r_reg[2];
        end
        sq     = r_reg[k_reg][R_W-1:0] * r_reg[k_reg][R_W-1:0];
        trial  = res_reg + bit_reg;
        len    = res_reg[ROOT_W-1:0];
        rem_sh = {rem_reg[ROOT_W-1:0], dvd_reg[DIV_W-1]};
        ge     = (rem_sh >= {1'b0, len});
    end

    always_comb
    begin
        state_next  = state_reg;
        emit_next   = emit_reg;
        entry_next  = entry_reg;
        k_next      = k_reg;
        cnt_next    = cnt_reg;
        n_next      = n_reg;
        r_next      = r_reg;
        p_next      = p_reg;
        sum_next    = sum_reg;
        res_next    = res_reg;
        bit_next    = bit_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        nrm_next    = nrm_reg;
        degen_next  = degen_reg;
        result_next = result_reg;
        strobe_next = 1'b0;
        pop         = 1'b0;
        load_next   = 1'b0;
        q           = '0;

        if (emit_reg)
        begin
            strobe_next = 1'b1;
            case (k_reg)
                2'd0:
                begin
                    result_next.vertex_x = entry_reg.verts.ax;
                    result_next.vertex_y = entry_reg.verts.ay;
                    result_next.vertex_z = entry_reg.verts.az;
                end
                2'd1:
                begin
                    result_next.vertex_x = entry_reg.verts.bx;
                    result_next.vertex_y = entry_reg.verts.by_coord;
                    result_next.vertex_z = entry_reg.verts.bz;
                end
                default:
                begin
                    result_next.vertex_x = entry_reg.verts.cx;
                    result_next.vertex_y = entry_reg.verts.cy;
                    result_next.vertex_z = entry_reg.verts.cz;
                end
            endcase
            if (entry_reg.flat)
            begin
                result_next.normal_x = nrm_reg[0];
                result_next.normal_y = nrm_reg[1];
                result_next.normal_z = nrm_reg[2];
            end
            else
            begin
                result_next.normal_x = result_next.vertex_x;
                result_next.normal_y = result_next.vertex_y;
                result_next.normal_z = result_next.vertex_z;
            end
            result_next.degenerate  = entry_reg.flat && degen_reg;
            result_next.last_vertex = (k_reg == 2'd2);
            if (k_reg == 2'd2)
            begin
                emit_next = 1'b0;
                load_next = 1'b1;
            end
            else
            begin
                k_next = k_reg + 2'd1;
            end
        end
        else
        begin
            case (state_reg)
                BK_IDLE:
                begin
                    load_next = 1'b1;
                end
                BK_CROSS:
                begin
                    n_next[k_reg] = {prod_a[PROD_W-1], prod_a}
                                  - {prod_b[PROD_W-1], prod_b};
                    if (k_reg == 2'd2)
                    begin
                        state_next = BK_MAG;
                    end
                    k_next = (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
                end
                BK_MAG:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        r_next[i] = n_reg[i][CROSS_W-1] ? CROSS_W'(-n_reg[i])
                                                        : CROSS_W'(n_reg[i]);
                    end
                    state_next = BK_MAX;
                end
                BK_MAX:
                begin
                    p_next = msb_index(m_max);
                    if (m_max == '0)
                    begin
                        degen_next = 1'b1;
                        for (int i = 0; i < 3; i++)
                        begin
                            nrm_next[i] = '0;
                        end
                        state_next = BK_IDLE;
                        emit_next  = 1'b1;
                        k_next     = 2'd0;
                    end
                    else
                    begin
                        degen_next = 1'b0;
                        state_next = BK_SHIFT;
                    end
                end
                BK_SHIFT:
                begin
                    // bring the largest magnitude's top bit to NORM_TOP
                    for (int i = 0; i < 3; i++)
                    begin
                        if (p_reg > POS_W'(NORM_TOP))
                        begin
                            r_next[i] = r_reg[i] >> (p_reg - POS_W'(NORM_TOP));
                        end
                        else
                        begin
                            r_next[i] = CROSS_W'(r_reg[i][R_W-1:0]
                                                 << (POS_W'(NORM_TOP) - p_reg));
                        end
                    end
                    state_next = BK_SQUARE;
                    k_next     = 2'd0;
                end
                BK_SQUARE:
                begin
                    sum_next = ((k_reg == 2'd0) ? '0 : sum_reg) + SUM_W'(sq);
                    if (k_reg == 2'd2)
                    begin
                        state_next = BK_ROOT;
                        k_next     = 2'd0;
                        res_next   = '0;
                        bit_next   = BIT_W'(1) << (SUM_W - 2);
                        cnt_next   = '0;
                    end
                    else
                    begin
                        k_next = k_reg + 2'd1;
                    end
                end
                BK_ROOT:
                begin
                    // one result bit per cycle, remainder kept in sum_reg
                    if ({1'b0, sum_reg} >= trial)
                    begin
                        sum_next = sum_reg - trial[SUM_W-1:0];
                        res_next = (res_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        res_next = res_reg >> 1;
                    end
                    bit_next = bit_reg >> 2;
                    if (cnt_reg == CNT_W'(ROOT_W - 1))
                    begin
                        state_next = BK_DIV;
                        cnt_next   = '0;
                        k_next     = 2'd0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                BK_DIV:
                begin
                    if (cnt_reg == '0)
                    begin
                        dvd_next = (DIV_W'(r_reg[k_reg][R_W-1:0]) << COORD_FRAC_BITS)
                                 + DIV_W'(len >> 1);
                        rem_next = '0;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    else
                    begin
                        // restoring division, one quotient bit per cycle
                        rem_next = ge ? rem_sh - {1'b0, len} : rem_sh;
                        dvd_next = {dvd_reg[DIV_W-2:0], ge};
                        if (cnt_reg == CNT_W'(DIV_W))
                        begin
                            q = dvd_next;
                            if (n_reg[k_reg][CROSS_W-1])
                            begin
                                nrm_next[k_reg] = (q >= DIV_W'(32768))
                                    ? COORD_W'(-32768) : COORD_W'(-q);
                            end
                            else
                            begin
                                nrm_next[k_reg] = (q >= DIV_W'(32767))
                                    ? COORD_W'(32767) : COORD_W'(q);
                            end
                            cnt_next = '0;
                            if (k_reg == 2'd2)
                            begin
                                state_next = BK_IDLE;
                                emit_next  = 1'b1;
                                k_next     = 2'd0;
                            end
                            else
                            begin
                                k_next = k_reg + 2'd1;
                            end
                        end
                        else
                        begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_next = BK_IDLE;
                end
            endcase
        end

        // take the next triangle as soon as the current one is done
        if (load_next)
        begin
            state_next = BK_IDLE;
            k_next     = 2'd0;
            if (!q_stat.empty)
            begin
                pop        = 1'b1;
                entry_next = q_stat.head;
                if (q_stat.head.flat)
                begin
                    state_next = BK_CROSS;
                end
                else
                begin
                    emit_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BK_IDLE;
            emit_reg   <= 1'b0;
            k_reg      <= 2'd0;
            cnt_reg    <= '0;
            strobe_reg <= 1'b0;
            degen_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            emit_reg   <= emit_next;
            k_reg      <= k_next;
            cnt_reg    <= cnt_next;
            strobe_reg <= strobe_next;
            degen_reg  <= degen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg  <= entry_next;
        n_reg      <= n_next;
        r_reg      <= r_next;
        p_reg      <= p_next;
        sum_reg    <= sum_next;
        res_reg    <= res_next;
        bit_reg    <= bit_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        nrm_reg    <= nrm_next;
        result_reg <= result_next;
    end

    assign result        = result_reg;
    assign result_strobe = strobe_reg;

endmodule

/* rtl/triangle_face_normal_shader.sv */
`timescale 1ns / 1ps
// triangle in, three vertex results out (a, b, c), each held on result for
// exactly one cycle with result_strobe high; the receiver cannot stall, so
// results leave at full rate. busy is high only while the two-entry queue
// between the front and the back is full. smooth mode: the back only emits
// the three results and pops the next triangle while it sends the last, so
// triangles are taken back to back. flat mode: the time per triangle is set
// by the bit-serial units of the back, in order: cross products, magnitude,
// maximum and shift, squaring, the square root, the three divisions, then
// the emit of the three results; a zero cross product skips straight to emit.
module triangle_face_normal_shader import tfn_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  tri_t    triangle,
    input  logic    cfg_we,
    input  logic    cfg_wdata,
    output result_t result,
    output logic    result_strobe
);

    // front to queue transaction and queue status
    q_push_t push;
    q_stat_t q_stat;
    logic    pop;

    // front: takes triangles, holds the shading mode register
    tfn_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .triangle  (triangle),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_stat    (q_stat),
        .busy      (busy),
        .push      (push)
    );

    // short queue decouples acceptance from the normal computation
    tfn_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (pop),
        .q_stat (q_stat)
    );

    // back: face normal sequencer and result emitter
    tfn_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_stat        (q_stat),
        .pop           (pop),
        .result        (result),
        .result_strobe (result_strobe)
    );

endmodule

/* rtl/tfn_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tfn_checker import tfn_pkg::*; (
    input logic    clk,
    input logic    rst_n,
    input result_t result,
    input logic    result_strobe
);

    `TFN_ASSERT_ALWAYS(a_no_strobe_in_reset, !rst_n |-> !result_strobe, "result during reset")
    `TFN_ASSERT(a_burst_continues, (result_strobe && !result.last_vertex) |=> result_strobe, "gap inside a triangle")
    `TFN_ASSERT(a_third_is_last, (result_strobe && !result.last_vertex && $past(result_strobe && !result.last_vertex)) |=> (result_strobe && result.last_vertex), "third result not last")
    `TFN_ASSERT(a_degen_zero, (result_strobe && result.degenerate) |-> (result.normal_x == 0 && result.normal_y == 0 && result.normal_z == 0), "degenerate with nonzero normal")

endmodule

bind triangle_face_normal_shader tfn_checker u_tfn_checker (.*);

/* verif/triangle_face_normal_shader_tb.sv */
`timescale 1ns / 1ps
module triangle_face_normal_shader_tb;
    import tfn_pkg::*;

    localparam int IDLE_PCT     = 37;
    localparam int RANDOM_TRIS  = 380;
    localparam int WATCHDOG_MAX = 4000;
    localparam int DRAIN_CYCLES = 300;

    // quick-pattern kinds for the random part
    typedef enum int {
        PAT_FULL,
        PAT_SMALL,
        PAT_COLLINEAR,
        PAT_EXTREME
    } pattern_t;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    tri_t    triangle;
    logic    cfg_we;
    logic    cfg_wdata;
    result_t result;
    logic    result_strobe;

    // expected vertex results, oldest first
    result_t vertex_queue[$];
    logic    flat_mode;
    int      mismatch_count;
    int      orphan_count;
    int      quiet_cycles;
    bit      no_idle;

    triangle_face_normal_shader DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .triangle     (triangle),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .result       (result),
        .result_strobe(result_strobe)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // exact integer square root, floor
    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = '0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // predicted three vertex results for one triangle under the current mode
    task automatic shade_triangle(input tri_t t);
        logic signed [63:0] vtx [3][3];
        logic signed [63:0] d1 [3];
        logic signed [63:0] d2 [3];
        logic signed [63:0] cr [3];
        logic signed [63:0] nrm [3];
        logic [63:0] mag [3];
        logic [63:0] peak;
        logic [63:0] len;
        logic [63:0] q;
        int msb;
        bit zero_cross;
        result_t r;
        vtx[0][0] = t.ax;  vtx[0][1] = t.ay;        vtx[0][2] = t.az;
        vtx[1][0] = t.bx;  vtx[1][1] = t.by_coord;  vtx[1][2] = t.bz;
        vtx[2][0] = t.cx;  vtx[2][1] = t.cy;        vtx[2][2] = t.cz;
        zero_cross = 1'b0;
        for (int k = 0; k < 3; k++)
            nrm[k] = 0;
        if (flat_mode)
        begin
            for (int k = 0; k < 3; k++)
            begin
                d1[k] = vtx[0][k] - vtx[1][k];
                d2[k] = vtx[1][k] - vtx[2][k];
            end
            cr[0] = d1[1] * d2[2] - d1[2] * d2[1];
            cr[1] = d1[2] * d2[0] - d1[0] * d2[2];
            cr[2] = d1[0] * d2[1] - d1[1] * d2[0];
            peak = 0;
            for (int k = 0; k < 3; k++)
            begin
                mag[k] = cr[k] < 0 ? -cr[k] : cr[k];
                if (mag[k] > peak)
                    peak = mag[k];
            end
            zero_cross = (peak == 0);
            if (!zero_cross)
            begin
                msb = 0;
                while (msb < 63 && (peak >> (msb + 1)) != 0)
                    msb++;
                // bring the largest magnitude's top bit to bit 29
                for (int k = 0; k < 3; k++)
                    mag[k] = (msb > 29) ? mag[k] >> (msb - 29) : mag[k] << (29 - msb);
                len = int_sqrt(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
                if (len == 0)
                    len = 1;
                for (int k = 0; k < 3; k++)
                begin
                    q = ((mag[k] << COORD_FRAC_BITS) + (len >> 1)) / len;
                    if (q > 65536)
                        q = 65536;
                    nrm[k] = cr[k] < 0 ? -$signed(q) : $signed(q);
                    if (nrm[k] > 32767)
                        nrm[k] = 32767;
                    if (nrm[k] < -32768)
                        nrm[k] = -32768;
                end
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            r.vertex_x    = vtx[i][0][15:0];
            r.vertex_y    = vtx[i][1][15:0];
            r.vertex_z    = vtx[i][2][15:0];
            r.normal_x    = flat_mode ? nrm[0][15:0] : vtx[i][0][15:0];
            r.normal_y    = flat_mode ? nrm[1][15:0] : vtx[i][1][15:0];
            r.normal_z    = flat_mode ? nrm[2][15:0] : vtx[i][2][15:0];
            r.degenerate  = flat_mode && zero_cross;
            r.last_vertex = (i == 2);
            vertex_queue.push_back(r);
        end
    endtask

    // compare every result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
        begin
            if (vertex_queue.size() == 0)
            begin
                orphan_count++;
                if (mismatch_count + orphan_count <= 10)
                    $display("unexpected result %h", result);
            end
            else
            begin
                result_t e;
                e = vertex_queue.pop_front();
                if (result.vertex_x !== e.vertex_x || result.vertex_y !== e.vertex_y ||
                    result.vertex_z !== e.vertex_z || result.normal_x !== e.normal_x ||
                    result.normal_y !== e.normal_y || result.normal_z !== e.normal_z ||
                    result.degenerate !== e.degenerate ||
                    result.last_vertex !== e.last_vertex)
                begin
                    mismatch_count++;
                    if (mismatch_count + orphan_count <= 10)
                        $display("mismatch: expected %h actual %h", e, result);
                end
            end
        end
    end

    // watchdog on cycles with no transaction either side
    always @(posedge clk)
    begin
        if (!rst_n || result_strobe || (start && !busy))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_MAX)
        begin
            $display("triangle_face_normal_shader_tb failed");
            $finish;
        end
    end

    // one triangle transaction, with random idle gaps ahead of it
    task automatic send_triangle(input tri_t t);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
            @(negedge clk);
        triangle = t;
        start    = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        shade_triangle(t);
        @(negedge clk);
        start = 1'b0;
    endtask

    // drain, then let the back finish before touching the register
    task automatic write_mode(input logic flat);
        while (vertex_queue.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = flat;
        @(negedge clk);
        cfg_we    = 1'b0;
        flat_mode = flat;
    endtask

    function automatic tri_t make_triangle(input pattern_t pat);
        tri_t t;
        logic [15:0] s;
        t = tri_t'({$urandom, $urandom, $urandom, $urandom, 16'($urandom)});
        case (pat)
            PAT_SMALL:
                t = tri_t'({9{16'($signed($urandom_range(0, 255)) - 128)}})
                    ^ (tri_t'({$urandom, $urandom, $urandom, $urandom, 16'($urandom)})
                       & tri_t'({9{16'h00ff}}));
            PAT_COLLINEAR:
            begin
                // c continues the a-b line so the cross product vanishes
                s = 16'($urandom_range(0, 200));
                t.bx = t.ax + s; t.by_coord = t.ay + s; t.bz = t.az + s;
                t.cx = t.bx + s; t.cy = t.by_coord + s; t.cz = t.bz + s;
                t.ax = t.ax & 16'h3fff; t.ay = t.ay & 16'h3fff; t.az = t.az & 16'h3fff;
                t.bx = t.ax + s; t.by_coord = t.ay + s; t.bz = t.az + s;
                t.cx = t.bx + s; t.cy = t.by_coord + s; t.cz = t.bz + s;
            end
            PAT_EXTREME:
                for (int k = 0; k < 9; k++)
                    t[k*16 +: 16] = $urandom_range(1) ? 16'h7fff : 16'h8000;
            default: ;
        endcase
        return t;
    endfunction

    // directed rows: triangle, mode, and whether a fixed result is typed in
    typedef struct {
        tri_t    verts;
        logic    flat;
        bit      fixed;
        result_t first;
    } row_t;

    row_t rows[$];

    initial
    begin
        row_t  rw;
        tri_t  t;
        pattern_t pat;
        rst_n          = 1'b0;
        start          = 1'b0;
        triangle       = '0;
        cfg_we         = 1'b0;
        cfg_wdata      = 1'b0;
        flat_mode      = 1'b1;
        mismatch_count = 0;
        orphan_count   = 0;
        quiet_cycles   = 0;
        no_idle        = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // flat after reset: unit triangle in the xy plane gives +z normal
        rw.verts = '{ax:16'sd0, ay:16'sd0, az:16'sd0, bx:16'sd16384, by_coord:16'sd0,
                     bz:16'sd0, cx:16'sd16384, cy:16'sd16384, cz:16'sd0};
        rw.flat = 1'b1; rw.fixed = 1'b1;
        rw.first = '{vertex_x:16'sd0, vertex_y:16'sd0, vertex_z:16'sd0, normal_x:16'sd0,
                     normal_y:16'sd0, normal_z:16'sd16384, degenerate:1'b0,
                     last_vertex:1'b0};
        rows.push_back(rw);
        // coincident vertices: degenerate, zero normal
        rw.verts = '{default:16'sh1234}; rw.flat = 1'b1;
        rw.first = '{vertex_x:16'sh1234, vertex_y:16'sh1234, vertex_z:16'sh1234,
                     normal_x:16'sd0, normal_y:16'sd0, normal_z:16'sd0, degenerate:1'b1,
                     last_vertex:1'b0};
        rows.push_back(rw);
        // all extremes
        rw.fixed = 1'b0;
        rw.verts = '{default:16'sh7fff};  rows.push_back(rw);
        rw.verts = '{default:-16'sh8000}; rows.push_back(rw);
        rw.verts = '{ax:16'sh7fff, ay:-16'sh8000, az:16'sh7fff, bx:-16'sh8000,
                     by_coord:16'sh7fff, bz:-16'sh8000, cx:16'sh7fff, cy:16'sh7fff,
                     cz:-16'sh8000};
        rows.push_back(rw);
        rw.verts = '{ax:-16'sh8000, ay:-16'sh8000, az:16'sh7fff, bx:16'sh7fff,
                     by_coord:-16'sh8000, bz:-16'sh8000, cx:-16'sh8000, cy:16'sh7fff,
                     cz:16'sh7fff};
        rows.push_back(rw);
        // tiny cross product, heavy left shift
        rw.verts = '{ax:16'sd0, ay:16'sd0, az:16'sd0, bx:16'sd1, by_coord:16'sd0,
                     bz:16'sd0, cx:16'sd1, cy:16'sd1, cz:16'sd0};
        rows.push_back(rw);
        // smooth mode: the vertex is its own normal
        rw.verts = '{ax:-16'sh8000, ay:16'sh7fff, az:16'sd0, bx:16'sd1, by_coord:-16'sd1,
                     bz:16'sh4000, cx:16'sh1234, cy:16'sh5678, cz:-16'sd2};
        rw.flat = 1'b0; rw.fixed = 1'b1;
        rw.first = '{vertex_x:-16'sh8000, vertex_y:16'sh7fff, vertex_z:16'sd0,
                     normal_x:-16'sh8000, normal_y:16'sh7fff, normal_z:16'sd0,
                     degenerate:1'b0, last_vertex:1'b0};
        rows.push_back(rw);
        // smooth with coincident vertices: no degenerate flag
        rw.verts = '{default:16'sd0}; rw.fixed = 1'b0;
        rows.push_back(rw);
        rw.verts = '{default:16'sh7fff}; rows.push_back(rw);
        rw.verts = '{ax:16'sd100, ay:-16'sd200, az:16'sd300, bx:16'sd5, by_coord:16'sd7,
                     bz:16'sd9, cx:-16'sd900, cy:16'sd11, cz:16'sd0};
        rw.flat = 1'b1; rows.push_back(rw);

        foreach (rows[i])
        begin
            if (rows[i].flat !== flat_mode)
                write_mode(rows[i].flat);
            send_triangle(rows[i].verts);
            // swap in the typed-in vertex a result where one is given
            if (rows[i].fixed)
                vertex_queue[vertex_queue.size() - 3] = rows[i].first;
        end

        // random part: bursts of smooth and flat settings, one stretch with no idle gaps
        for (int n = 0; n < RANDOM_TRIS; n++)
        begin
            if (n % 60 == 0)
                write_mode((n / 60) % 2 == 0 ? 1'b0 : 1'b1);
            no_idle = (n >= 120 && n < 170);
            pat = pattern_t'($urandom_range(0, 9) < 5 ? PAT_FULL :
                             $urandom_range(0, 2) == 0 ? PAT_EXTREME :
                             $urandom_range(0, 1) ? PAT_SMALL : PAT_COLLINEAR);
            t = make_triangle(pat);
            send_triangle(t);
        end

        while (vertex_queue.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && orphan_count == 0)
            $display("triangle_face_normal_shader_tb passed");
        else
            $display("triangle_face_normal_shader_tb failed");
        $finish;
    end
endmodule
